### rtl/rrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_MAP      = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_ADDED    = 3'd3,
    ST_GOAL     = 3'd4,
    ST_OVER     = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP   = 3'd0;
  localparam logic [2:0] CFG_GOAL_X = 3'd1;
  localparam logic [2:0] CFG_GOAL_Y = 3'd2;
  localparam logic [2:0] CFG_ROOT_X = 3'd3;
  localparam logic [2:0] CFG_ROOT_Y = 3'd4;
  localparam logic [2:0] CFG_AMIN   = 3'd5;
  localparam logic [2:0] CFG_AMAX   = 3'd6;
  localparam logic [2:0] CFG_MAXS   = 3'd7;

  // divide / square root unit operations
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } dsq_op_t;

  typedef struct packed {
    logic    go;
    dsq_op_t op;
  } dsq_ctl_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  node_index;
    logic [15:0] node_x;
    logic [15:0] node_y;
    logic [9:0]  parent_index;
    logic        last;
  } res_t;

  function automatic res_t mk_res(status_t st, logic [9:0] idx, logic [15:0] x,
                                  logic [15:0] y, logic [9:0] par, logic lst);
    res_t r;
    r.status       = st;
    r.node_index   = idx;
    r.node_x       = x;
    r.node_y       = y;
    r.parent_index = par;
    r.last         = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/rrt_dsq.sv
`timescale 1ns / 1ps
`default_nettype none
module rrt_dsq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rrt_pkg::dsq_ctl_t ctl,
  input  wire logic [63:0]       dividend,
  input  wire logic [33:0]       divisor,
  output logic                   done,
  output logic [31:0]            result
);
  import rrt_pkg::*;

  logic        run;
  dsq_op_t     op;
  logic [4:0]  cnt;
  logic [34:0] rem;
  logic [31:0] low;
  logic [31:0] quo;
  logic [31:0] sv;
  logic [31:0] sr;
  logic [31:0] sbit;

  logic [34:0] t;
  logic        ge;
  logic [31:0] sum;
  logic        ge2;

  // one quotient bit or one root bit per cycle
  assign t   = {rem[33:0], low[31]};
  assign ge  = t >= {1'b0, divisor};
  assign sum = sr + sbit;
  assign ge2 = sv >= sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        run <= 1'b1;
        cnt <= (ctl.op == OP_DIV) ? 5'd31 : 5'd15;
      end else if (run) begin
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      op   <= ctl.op;
      rem  <= {3'b0, dividend[63:32]};
      low  <= dividend[31:0];
      sv   <= dividend[31:0];
      sr   <= '0;
      sbit <= 32'h4000_0000;
    end else if (run) begin
      if (op == OP_DIV) begin
        rem <= ge ? (t - {1'b0, divisor}) : t;
        low <= {low[30:0], 1'b0};
        quo <= {quo[30:0], ge};
      end else begin
        sv   <= ge2 ? (sv - sum) : sv;
        sr   <= ge2 ? ((sr >> 1) + sbit) : (sr >> 1);
        sbit <= sbit >> 2;
      end
    end
  end

  assign result = (op == OP_DIV) ? quo : sr;

endmodule
`default_nettype wire

### rtl/rrt_map.sv
`timescale 1ns / 1ps
`default_nettype none
module rrt_map #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [$clog2(GRID_SIZE)-1:0] rd_row,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(GRID_SIZE)-1:0] wr_row,
  input  wire logic [GRID_SIZE-1:0]         wr_data,
  output logic [GRID_SIZE-1:0]              rd_data
);
  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld;
  logic [GRID_SIZE-1:0] rd_q;
  logic                 vld_q;

  // a row never written reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) row_vld[wr_row] <= 1'b1;
      vld_q <= row_vld[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= wr_data;
    rd_q <= mem[rd_row];
  end

  assign rd_data = vld_q ? rd_q : '0;

endmodule
`default_nettype wire

### rtl/rrt_nodes.sv
`timescale 1ns / 1ps
`default_nettype none
module rrt_nodes #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                         clk,
  input  wire logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  wire logic [15:0]                  wr_x,
  input  wire logic [15:0]                  wr_y,
  input  wire logic [15:0]                  root_x,
  input  wire logic [15:0]                  root_y,
  output logic [15:0]                       rd_x,
  output logic [15:0]                       rd_y
);
  logic [31:0] mem [MAX_NODES];
  logic [31:0] rd_q;
  logic        root_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_x, wr_y};
    rd_q   <= mem[rd_addr];
    root_q <= (rd_addr == '0);
  end

  // node 0 follows the root registers
  assign rd_x = root_q ? root_x : rd_q[31:16];
  assign rd_y = root_q ? root_y : rd_q[15:0];

endmodule
`default_nettype wire

### rtl/rrt_tree_extend.sv
// a map write reads the row, then writes it back with the cell; a search-over answer comes
// from idle; a sample scans all N stored nodes, steers, checks up to CHECK_STEPS+1 segment
// points, plus the goal segment when the goal lies within step. nearest scan squares each
// axis on the one multiplier; offsets go through the shared divide/root unit at one bit per
// cycle, segment cells take one reciprocal product per axis. one item at a time, busy falls
// as the last word appears; the receiver cannot stall. reset: control and config registers.
`timescale 1ns / 1ps
`default_nettype none
module rrt_tree_extend #(
  parameter int GRID_SIZE   = 32,
  parameter int MAX_NODES   = 1024,
  parameter int CHECK_STEPS = 10,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [4:0]  cell_col,
  input  wire logic [4:0]  cell_row,
  input  wire logic        cell_blocked,
  input  wire logic [15:0] sample_x,
  input  wire logic [15:0] sample_y,
  output logic             done,
  output logic [2:0]       status,
  output logic [9:0]       node_index,
  output logic [15:0]      node_x,
  output logic [15:0]      node_y,
  output logic [9:0]       parent_index,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rrt_pkg::*;

  localparam int AW        = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int RW        = $clog2(GRID_SIZE);
  localparam int EW        = (RW > 5) ? RW : 5;
  localparam int KW        = $clog2(CHECK_STEPS + 1);
  localparam int SEG_HALF  = CHECK_STEPS << (FRAC_BITS - 1);
  // cell = floor((num >> FRAC_BITS) / CHECK_STEPS), exact by a rounded-up reciprocal
  localparam int SEG_SH    = 28;
  localparam int SEG_RECIP = ((1 << SEG_SH) + CHECK_STEPS - 1) / CHECK_STEPS;

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_MAP_RD   = 23'h000002,
    S_MAP_WR   = 23'h000004,
    S_SCAN_RD  = 23'h000008,
    S_SCAN_X   = 23'h000010,
    S_SCAN_Y   = 23'h000020,
    S_STEP     = 23'h000040,
    S_PROD     = 23'h000080,
    S_PSQ      = 23'h000100,
    S_DIV      = 23'h000200,
    S_SQRT     = 23'h000400,
    S_AREA     = 23'h000800,
    S_SEG_INIT = 23'h001000,
    S_SEG_NUMY = 23'h002000,
    S_SEG_DIVX = 23'h004000,
    S_SEG_DIVY = 23'h008000,
    S_SEG_CHK  = 23'h010000,
    S_SEG_MAP  = 23'h020000,
    S_STORE    = 23'h040000,
    S_GOAL_X   = 23'h080000,
    S_GOAL_Y   = 23'h100000,
    S_GOAL_CMP = 23'h200000,
    S_EMIT2    = 23'h400000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] step_length;
  logic [15:0] goal_x;
  logic [15:0] goal_y;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] area_min;
  logic [15:0] area_max;
  logic [9:0]  max_samples;

  // tree bookkeeping
  logic [CNT_W-1:0] tree_count;
  logic [9:0]       samples_used;
  logic             search_over;

  // latched input word
  logic [4:0]  it_col;
  logic [4:0]  it_row;
  logic        it_blk;
  logic [15:0] sx;
  logic [15:0] sy;

  // nearest scan
  logic [CNT_W-1:0] scan_i;
  logic [34:0]      acc;
  logic [34:0]      best;
  logic [AW-1:0]    near_i;
  logic [15:0]      nx;
  logic [15:0]      ny;

  // steering
  logic               axis;
  logic [31:0]        prod;
  logic signed [17:0] px;
  logic signed [17:0] py;
  logic [AW-1:0]      ni;

  // segment check
  logic [15:0]   seg_ax;
  logic [15:0]   seg_ay;
  logic [15:0]   seg_bx;
  logic [15:0]   seg_by;
  logic          seg_goal;
  logic [25:0]   num_x;
  logic [25:0]   num_y;
  logic [KW-1:0] seg_i;
  logic [RW-1:0] cx_idx;
  logic [RW-1:0] cy_idx;
  logic          cx_out;
  logic          cy_out;
  logic [31:0]   seg_q;

  // shared divide / root unit
  dsq_ctl_t    dsq_ctl;
  logic [63:0] dvd;
  logic [33:0] dvs;
  logic        dsq_done;
  logic [31:0] dsq_res;

  res_t res;

  // memories
  logic [15:0]          nd_x;
  logic [15:0]          nd_y;
  logic [AW-1:0]        nrd_addr;
  logic [CNT_W-1:0]     scan_nx;
  logic                 nwr_en;
  logic [15:0]          nwr_x;
  logic [15:0]          nwr_y;
  logic [GRID_SIZE-1:0] map_rd;
  logic [GRID_SIZE-1:0] map_wd;
  logic [RW-1:0]        map_rd_row;
  logic [EW-1:0]        col_ext;
  logic [EW-1:0]        row_ext;
  logic                 cell_in_grid;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;

  // datapath helpers
  logic signed [16:0] ex;
  logic signed [16:0] ey;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] cur_d;
  logic [15:0]        mag;
  logic signed [18:0] gdx;
  logic signed [18:0] gdy;
  logic [34:0]        d_scan;
  logic signed [17:0] off;
  logic signed [16:0] dlx;
  logic signed [16:0] dly;
  logic [25:0]        num_x_nx;
  logic [25:0]        num_y_nx;
  logic               full;
  logic               map_bit;
  logic               seg_fin;
  logic               seg_hit;
  logic               accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign ex     = $signed({1'b0, sx}) - $signed({1'b0, nd_x});
  assign ey     = $signed({1'b0, sy}) - $signed({1'b0, nd_y});
  assign dx     = $signed({1'b0, sx}) - $signed({1'b0, nx});
  assign dy     = $signed({1'b0, sy}) - $signed({1'b0, ny});
  assign cur_d  = axis ? dy : dx;
  assign mag    = cur_d[16] ? 16'(-cur_d) : cur_d[15:0];
  assign gdx    = 19'(px) - $signed({3'b0, goal_x});
  assign gdy    = 19'(py) - $signed({3'b0, goal_y});
  assign d_scan = acc + {1'b0, mul_p[33:0]};
  assign off    = cur_d[16] ? -$signed({2'b0, dsq_res[15:0]}) : $signed({2'b0, dsq_res[15:0]});
  assign dlx    = $signed({1'b0, seg_bx}) - $signed({1'b0, seg_ax});
  assign dly    = $signed({1'b0, seg_by}) - $signed({1'b0, seg_ay});
  assign num_x_nx = num_x + 26'(dlx);
  assign num_y_nx = num_y + 26'(dly);
  assign full   = tree_count >= CNT_W'(MAX_NODES);
  assign map_bit = map_rd[cx_idx];
  assign seg_q  = mul_p[SEG_SH+31:SEG_SH];

  // map cell of a write word
  assign col_ext      = EW'(it_col);
  assign row_ext      = EW'(it_row);
  assign cell_in_grid = (32'(it_col) < 32'(GRID_SIZE)) && (32'(it_row) < 32'(GRID_SIZE));

  always_comb begin
    map_wd = map_rd;
    map_wd[col_ext[RW-1:0]] = it_blk;
  end

  assign map_rd_row = (state == S_MAP_RD) ? row_ext[RW-1:0] : cy_idx;

  // segment walk ends on a blocked or off-grid point, or after the last point
  assign seg_fin = ((state == S_SEG_CHK) && (cx_out || cy_out)) ||
                   ((state == S_SEG_MAP) && (map_bit || (seg_i == KW'(CHECK_STEPS))));
  assign seg_hit = (state == S_SEG_CHK) ? 1'b1 : map_bit;

  // node memory ports: read ahead one node during the scan
  assign scan_nx  = scan_i + CNT_W'(1);
  assign nrd_addr = (state == S_SCAN_Y) ? scan_nx[AW-1:0] : scan_i[AW-1:0];
  assign nwr_en   = (state == S_STORE) || ((state == S_EMIT2) && !full);
  assign nwr_x    = (state == S_STORE) ? px[15:0] : goal_x;
  assign nwr_y    = (state == S_STORE) ? py[15:0] : goal_y;

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SCAN_X: begin
        mul_a = 34'(ex);
        mul_b = 34'(ex);
      end
      S_SCAN_Y: begin
        mul_a = 34'(ey);
        mul_b = 34'(ey);
      end
      S_PROD: begin
        mul_a = $signed({18'b0, step_length});
        mul_b = $signed({18'b0, mag});
      end
      S_PSQ: begin
        mul_a = $signed({2'b0, prod});
        mul_b = $signed({2'b0, prod});
      end
      S_SEG_INIT: begin
        mul_a = $signed({18'b0, seg_ax});
        mul_b = 34'(CHECK_STEPS);
      end
      S_SEG_NUMY: begin
        mul_a = $signed({18'b0, seg_ay});
        mul_b = 34'(CHECK_STEPS);
      end
      S_SEG_DIVX: begin
        mul_a = 34'(num_x >> FRAC_BITS);
        mul_b = 34'(SEG_RECIP);
      end
      S_SEG_DIVY: begin
        mul_a = 34'(num_y >> FRAC_BITS);
        mul_b = 34'(SEG_RECIP);
      end
      S_GOAL_X: begin
        mul_a = 34'(gdx);
        mul_b = 34'(gdx);
      end
      S_GOAL_Y: begin
        mul_a = 34'(gdy);
        mul_b = 34'(gdy);
      end
      S_GOAL_CMP: begin
        mul_a = $signed({18'b0, step_length});
        mul_b = $signed({18'b0, step_length});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= 16'd256;
      goal_x      <= 16'd5120;
      goal_y      <= 16'd5120;
      start_x     <= 16'd256;
      start_y     <= 16'd256;
      area_min    <= 16'd256;
      area_max    <= 16'd5120;
      max_samples <= 10'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP:   step_length <= cfg_data;
        CFG_GOAL_X: goal_x      <= cfg_data;
        CFG_GOAL_Y: goal_y      <= cfg_data;
        CFG_ROOT_X: start_x     <= cfg_data;
        CFG_ROOT_Y: start_y     <= cfg_data;
        CFG_AMIN:   area_min    <= cfg_data;
        CFG_AMAX:   area_max    <= cfg_data;
        CFG_MAXS:   max_samples <= cfg_data[9:0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      tree_count   <= CNT_W'(1);
      samples_used <= '0;
      search_over  <= 1'b0;
      dsq_ctl      <= '{go: 1'b0, op: OP_DIV};
    end else begin
      done       <= 1'b0;
      dsq_ctl.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            it_col <= cell_col;
            it_row <= cell_row;
            it_blk <= cell_blocked;
            sx     <= sample_x;
            sy     <= sample_y;
            if (!mode) begin
              state <= S_MAP_RD;
            end else if (search_over || (samples_used >= max_samples)) begin
              // search already over: answer at once, not counted
              search_over <= 1'b1;
              done        <= 1'b1;
              res         <= mk_res(ST_OVER, '0, '0, '0, '0, 1'b1);
            end else begin
              samples_used <= samples_used + 10'd1;
              scan_i       <= '0;
              state        <= S_SCAN_RD;
            end
          end
        end
        S_MAP_RD: state <= S_MAP_WR;
        S_MAP_WR: begin
          done  <= 1'b1;
          res   <= mk_res(ST_MAP, '0, '0, '0, '0, 1'b1);
          state <= S_IDLE;
        end
        S_SCAN_RD: state <= S_SCAN_X;
        S_SCAN_X: begin
          acc   <= {1'b0, mul_p[33:0]};
          state <= S_SCAN_Y;
        end
        S_SCAN_Y: begin
          // strict compare keeps the first node on ties
          if ((scan_i == '0) || (d_scan < best)) begin
            best   <= d_scan;
            near_i <= scan_i[AW-1:0];
            nx     <= nd_x;
            ny     <= nd_y;
          end
          if (scan_nx == tree_count) begin
            state <= S_STEP;
          end else begin
            scan_i <= scan_nx;
            state  <= S_SCAN_X;
          end
        end
        S_STEP: begin
          if (best == '0) begin
            // sample on the node itself: step along +x
            px    <= $signed({2'b0, nx}) + $signed({2'b0, step_length});
            py    <= $signed({2'b0, ny});
            state <= S_AREA;
          end else begin
            axis  <= 1'b0;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          prod  <= mul_p[31:0];
          state <= S_PSQ;
        end
        S_PSQ: begin
          // (step*|d|)^2 / d2, root taken next
          dvd     <= mul_p[63:0];
          dvs     <= best[33:0];
          dsq_ctl <= '{go: 1'b1, op: OP_DIV};
          state   <= S_DIV;
        end
        S_DIV: begin
          if (dsq_done) begin
            dvd     <= {32'b0, dsq_res};
            dsq_ctl <= '{go: 1'b1, op: OP_SQRT};
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (dsq_done) begin
            if (!axis) begin
              px    <= $signed({2'b0, nx}) + off;
              axis  <= 1'b1;
              state <= S_PROD;
            end else begin
              py    <= $signed({2'b0, ny}) + off;
              state <= S_AREA;
            end
          end
        end
        S_AREA: begin
          if ((px < $signed({2'b0, area_min})) || (px > $signed({2'b0, area_max})) ||
              (py < $signed({2'b0, area_min})) || (py > $signed({2'b0, area_max}))) begin
            done  <= 1'b1;
            res   <= mk_res(ST_OUTSIDE, '0, px[15:0], py[15:0], 10'(near_i), 1'b1);
            state <= S_IDLE;
          end else begin
            seg_ax   <= nx;
            seg_ay   <= ny;
            seg_bx   <= px[15:0];
            seg_by   <= py[15:0];
            seg_goal <= 1'b0;
            state    <= S_SEG_INIT;
          end
        end
        S_SEG_INIT: begin
          num_x <= mul_p[25:0] + 26'(SEG_HALF);
          seg_i <= '0;
          state <= S_SEG_NUMY;
        end
        S_SEG_NUMY: begin
          num_y <= mul_p[25:0] + 26'(SEG_HALF);
          state <= S_SEG_DIVX;
        end
        S_SEG_DIVX: begin
          cx_idx <= seg_q[RW-1:0];
          cx_out <= seg_q >= 32'(GRID_SIZE);
          state  <= S_SEG_DIVY;
        end
        S_SEG_DIVY: begin
          cy_idx <= seg_q[RW-1:0];
          cy_out <= seg_q >= 32'(GRID_SIZE);
          state  <= S_SEG_CHK;
        end
        S_SEG_CHK: begin
          if (!seg_fin) state <= S_SEG_MAP;
        end
        S_SEG_MAP: begin
          // next point along the segment
          if (!seg_fin) begin
            num_x <= num_x_nx;
            num_y <= num_y_nx;
            seg_i <= seg_i + KW'(1);
            state <= S_SEG_DIVX;
          end
        end
        S_STORE: begin
          ni         <= tree_count[AW-1:0];
          tree_count <= tree_count + CNT_W'(1);
          state      <= S_GOAL_X;
        end
        S_GOAL_X: begin
          acc   <= mul_p[34:0];
          state <= S_GOAL_Y;
        end
        S_GOAL_Y: begin
          acc   <= acc + mul_p[34:0];
          state <= S_GOAL_CMP;
        end
        S_GOAL_CMP: begin
          if (acc <= mul_p[34:0]) begin
            seg_ax   <= px[15:0];
            seg_ay   <= py[15:0];
            seg_bx   <= goal_x;
            seg_by   <= goal_y;
            seg_goal <= 1'b1;
            state    <= S_SEG_INIT;
          end else begin
            done  <= 1'b1;
            res   <= mk_res(ST_ADDED, 10'(ni), px[15:0], py[15:0], 10'(near_i), 1'b1);
            state <= S_IDLE;
          end
        end
        S_EMIT2: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (full) begin
            // goal found but no slot left: search goes on
            res <= mk_res(ST_FULL, '0, goal_x, goal_y, 10'(ni), 1'b1);
          end else begin
            res         <= mk_res(ST_GOAL, 10'(tree_count), goal_x, goal_y, 10'(ni), 1'b1);
            tree_count  <= tree_count + CNT_W'(1);
            search_over <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase

      // end of a segment walk
      if (seg_fin) begin
        if (!seg_goal) begin
          if (seg_hit) begin
            done  <= 1'b1;
            res   <= mk_res(ST_BLOCKED, '0, px[15:0], py[15:0], 10'(near_i), 1'b1);
            state <= S_IDLE;
          end else if (full) begin
            done  <= 1'b1;
            res   <= mk_res(ST_FULL, '0, px[15:0], py[15:0], 10'(near_i), 1'b1);
            state <= S_IDLE;
          end else begin
            state <= S_STORE;
          end
        end else begin
          done <= 1'b1;
          if (seg_hit) begin
            res   <= mk_res(ST_ADDED, 10'(ni), px[15:0], py[15:0], 10'(near_i), 1'b1);
            state <= S_IDLE;
          end else begin
            res   <= mk_res(ST_ADDED, 10'(ni), px[15:0], py[15:0], 10'(near_i), 1'b0);
            state <= S_EMIT2;
          end
        end
      end
    end
  end

  assign status       = res.status;
  assign node_index   = res.node_index;
  assign node_x       = res.node_x;
  assign node_y       = res.node_y;
  assign parent_index = res.parent_index;
  assign last         = res.last;

  rrt_dsq u_dsq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dsq_ctl),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (dsq_done),
    .result   (dsq_res)
  );

  rrt_map #(.GRID_SIZE(GRID_SIZE)) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_row  (map_rd_row),
    .wr_en   ((state == S_MAP_WR) && cell_in_grid),
    .wr_row  (row_ext[RW-1:0]),
    .wr_data (map_wd),
    .rd_data (map_rd)
  );

  rrt_nodes #(.MAX_NODES(MAX_NODES)) u_nodes (
    .clk     (clk),
    .rd_addr (nrd_addr),
    .wr_en   (nwr_en),
    .wr_addr (tree_count[AW-1:0]),
    .wr_x    (nwr_x),
    .wr_y    (nwr_y),
    .root_x  (start_x),
    .root_y  (start_y),
    .rd_x    (nd_x),
    .rd_y    (nd_y)
  );

endmodule
`default_nettype wire

### rtl/rrt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module rrt_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic       last
);
  import rrt_pkg::*;

  // only a node-added word may be followed by a second one
  a_last: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_ADDED) |-> last)
    else $error("non-final word with wrong status");

  // a non-final word is followed at once by the goal or table-full word
  a_second: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && ((status == ST_GOAL) || (status == ST_FULL)))
    else $error("second word missing");

  a_pair_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy)
    else $error("idle between the two words");

  // an accepted word either starts work or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (done && last))
    else $error("accepted word dropped");

  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind rrt_tree_extend rrt_chk u_rrt_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .last   (last)
);
`default_nettype wire
